[hw/rtl/rpdc_pkg.sv]
// ----------------------------------------------------------------------------
// rpdc_pkg
// Shared types and constants for the range paint / distinct color counter.
// ----------------------------------------------------------------------------
`default_nettype none
package rpdc_pkg;

  localparam int MAX_POSITIONS = 1024;
  localparam int COLOR_COUNT   = 30;
  localparam int ADDR_W        = $clog2(MAX_POSITIONS);
  localparam int LEN_W         = 11;
  localparam int COLOR_W       = 5;
  localparam int CNT_W         = 5;

  localparam logic REQ_PAINT = 1'b0;
  localparam logic REQ_COUNT = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [ADDR_W-1:0]  lo;
    logic [ADDR_W-1:0]  hi;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_RUN,
    BS_DRAIN,
    BS_FIN
  } bst_t;

endpackage
`default_nettype wire

[hw/rtl/rpdc_front.sv]
// ----------------------------------------------------------------------------
// rpdc_front
// Holds the row length, clamps and orders the bounds, drops void paints.
// ----------------------------------------------------------------------------
`default_nettype none
module rpdc_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_fire,
  input  wire logic [rpdc_pkg::LEN_W-1:0]    cfg_data,
  input  wire logic                          fire,
  input  wire logic                          req_type,
  input  wire logic [rpdc_pkg::LEN_W-1:0]    left_pos,
  input  wire logic [rpdc_pkg::LEN_W-1:0]    right_pos,
  input  wire logic [rpdc_pkg::COLOR_W-1:0]  color,
  output rpdc_pkg::cmd_t                     q_data,
  output logic                               q_push
);

  logic [rpdc_pkg::LEN_W-1:0] len;
  logic [rpdc_pkg::LEN_W-1:0] len_next;
  logic [rpdc_pkg::LEN_W-1:0] pa, pb;
  logic [rpdc_pkg::ADDR_W-1:0] aa, ab;
  logic color_ok;

  always_comb begin
    if (cfg_data == '0) begin
      len_next = rpdc_pkg::LEN_W'(1);
    end else if (cfg_data > rpdc_pkg::LEN_W'(rpdc_pkg::MAX_POSITIONS)) begin
      len_next = rpdc_pkg::LEN_W'(rpdc_pkg::MAX_POSITIONS);
    end else begin
      len_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= rpdc_pkg::LEN_W'(rpdc_pkg::MAX_POSITIONS);
    end else if (cfg_fire) begin
      len <= len_next;
    end
  end

  always_comb begin
    if (left_pos == '0) pa = rpdc_pkg::LEN_W'(1);
    else if (left_pos > len) pa = len;
    else pa = left_pos;
    if (right_pos == '0) pb = rpdc_pkg::LEN_W'(1);
    else if (right_pos > len) pb = len;
    else pb = right_pos;
    aa = rpdc_pkg::ADDR_W'(pa - rpdc_pkg::LEN_W'(1));
    ab = rpdc_pkg::ADDR_W'(pb - rpdc_pkg::LEN_W'(1));
    color_ok = (color != '0) && (color <= rpdc_pkg::COLOR_W'(rpdc_pkg::COLOR_COUNT));
    q_data.kind  = req_type;
    q_data.lo    = (aa > ab) ? ab : aa;
    q_data.hi    = (aa > ab) ? aa : ab;
    q_data.color = color;
    q_push = fire && ((req_type == rpdc_pkg::REQ_COUNT) || color_ok);
  end

endmodule
`default_nettype wire

[hw/rtl/rpdc_queue.sv]
// ----------------------------------------------------------------------------
// rpdc_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module rpdc_queue (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr,
  input  wire rpdc_pkg::cmd_t wdata,
  input  wire logic  rd,
  output rpdc_pkg::cmd_t rdata,
  output logic       q_full,
  output logic       q_empty
);

  rpdc_pkg::cmd_t slots [2];
  logic       wptr, rptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wptr] <= wdata;
  end

  assign rdata   = slots[rptr];
  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);

endmodule
`default_nettype wire

[hw/rtl/rpdc_back.sv]
// ----------------------------------------------------------------------------
// rpdc_back
// Color memory, range sweep for paint and count, clear pass, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module rpdc_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_fire,
  input  wire logic                         q_empty,
  input  wire rpdc_pkg::cmd_t               q_data,
  output logic                              q_pop,
  output logic                              clearing,
  output logic                              res_valid,
  input  wire logic                         res_take,
  output logic [rpdc_pkg::CNT_W-1:0]        res_count
);

  rpdc_pkg::bst_t state, state_next;
  rpdc_pkg::cmd_t cmd;
  logic [rpdc_pkg::ADDR_W-1:0]  ptr;
  logic [rpdc_pkg::COLOR_W-1:0] mem [rpdc_pkg::MAX_POSITIONS];
  logic [rpdc_pkg::COLOR_W-1:0] rdata;
  logic [rpdc_pkg::COLOR_W-1:0] wdata;
  logic                         we;
  logic                         rd_en;
  logic                         rd_valid;
  logic [rpdc_pkg::COLOR_COUNT-1:0] mask;
  logic [rpdc_pkg::CNT_W-1:0]   pop_cnt;
  logic                         at_end;

  assign at_end = (ptr == cmd.hi);

  always_comb begin
    state_next = state;
    case (state)
      rpdc_pkg::BS_CLEAR: if (ptr == '1) state_next = rpdc_pkg::BS_IDLE;
      rpdc_pkg::BS_IDLE: begin
        if (!q_empty && (q_data.kind == rpdc_pkg::REQ_PAINT || !res_valid))
          state_next = rpdc_pkg::BS_RUN;
      end
      rpdc_pkg::BS_RUN: begin
        if (at_end)
          state_next = (cmd.kind == rpdc_pkg::REQ_COUNT) ? rpdc_pkg::BS_DRAIN
                                                          : rpdc_pkg::BS_IDLE;
      end
      rpdc_pkg::BS_DRAIN: state_next = rpdc_pkg::BS_FIN;
      rpdc_pkg::BS_FIN:   state_next = rpdc_pkg::BS_IDLE;
      default:            state_next = rpdc_pkg::BS_CLEAR;
    endcase
    if (cfg_fire) state_next = rpdc_pkg::BS_CLEAR;
  end

  always_comb begin
    q_pop    = 1'b0;
    we       = 1'b0;
    rd_en    = 1'b0;
    wdata    = cmd.color;
    clearing = 1'b0;
    case (state)
      rpdc_pkg::BS_CLEAR: begin
        we       = 1'b1;
        wdata    = rpdc_pkg::COLOR_W'(1);
        clearing = 1'b1;
      end
      rpdc_pkg::BS_IDLE:
        q_pop = !q_empty && (q_data.kind == rpdc_pkg::REQ_PAINT || !res_valid);
      rpdc_pkg::BS_RUN: begin
        we    = (cmd.kind == rpdc_pkg::REQ_PAINT);
        rd_en = (cmd.kind == rpdc_pkg::REQ_COUNT);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rpdc_pkg::BS_CLEAR;
      ptr       <= '0;
      rd_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en;
      if (cfg_fire) begin
        ptr <= '0;
      end else if (q_pop) begin
        ptr <= q_data.lo;
      end else if (state == rpdc_pkg::BS_CLEAR || state == rpdc_pkg::BS_RUN) begin
        ptr <= ptr + rpdc_pkg::ADDR_W'(1);
      end
      if (state == rpdc_pkg::BS_FIN) res_valid <= 1'b1;
      else if (res_take) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd  <= q_data;
      mask <= '0;
    end else if (rd_valid) begin
      mask <= mask | (rpdc_pkg::COLOR_COUNT'(1) << (rdata - rpdc_pkg::COLOR_W'(1)));
    end
    if (state == rpdc_pkg::BS_FIN) res_count <= pop_cnt;
  end

  always_ff @(posedge clk) begin
    if (we) mem[ptr] <= wdata;
    rdata <= mem[ptr];
  end

  always_comb begin
    pop_cnt = '0;
    for (int i = 0; i < rpdc_pkg::COLOR_COUNT; i++)
      pop_cnt = pop_cnt + rpdc_pkg::CNT_W'(mask[i]);
  end

endmodule
`default_nettype wire

[hw/rtl/range_paint_distinct_color_count.sv]
// ----------------------------------------------------------------------------
// range_paint_distinct_color_count
// Paints position ranges with colors and counts distinct colors in a range.
// ----------------------------------------------------------------------------
// Colors live in a single-port memory of one entry per position, and the back
// end sweeps a range one position per cycle. After reset and after every length
// write a clear pass repaints the row with color 1; full stays high meanwhile.
// A two-entry command queue lets the front accept while the back sweeps; one
// result waits in a register.
`default_nettype none
module range_paint_distinct_color_count (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          req_type,
  input  wire logic [rpdc_pkg::LEN_W-1:0]    left_pos,
  input  wire logic [rpdc_pkg::LEN_W-1:0]    right_pos,
  input  wire logic [rpdc_pkg::COLOR_W-1:0]  color,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [rpdc_pkg::CNT_W-1:0]         distinct_count,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rpdc_pkg::LEN_W-1:0]    cfg_data
);

  rpdc_pkg::cmd_t f_cmd, q_cmd;
  logic f_push, q_pop, q_full, q_empty, clearing, res_valid, cfg_fire, in_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign full      = q_full || clearing;
  assign in_fire   = push && !full;
  assign empty     = !res_valid;

  rpdc_front u_front (
    .clk(clk), .rst(rst), .cfg_fire(cfg_fire), .cfg_data(cfg_data),
    .fire(in_fire), .req_type(req_type), .left_pos(left_pos),
    .right_pos(right_pos), .color(color), .q_data(f_cmd), .q_push(f_push)
  );

  rpdc_queue u_queue (
    .clk(clk), .rst(rst), .wr(f_push), .wdata(f_cmd), .rd(q_pop),
    .rdata(q_cmd), .q_full(q_full), .q_empty(q_empty)
  );

  rpdc_back u_back (
    .clk(clk), .rst(rst), .cfg_fire(cfg_fire), .q_empty(q_empty),
    .q_data(q_cmd), .q_pop(q_pop), .clearing(clearing),
    .res_valid(res_valid), .res_take(pop && res_valid),
    .res_count(distinct_count)
  );

endmodule
`default_nettype wire

[verif/range_paint_distinct_color_count_test.sv]
// ----------------------------------------------------------------------------
// range_paint_distinct_color_count_test
// Self-checking bench for the range paint / distinct color counter. A table
// of directed requests is followed by random paint and count traffic under
// several row lengths. A flat color row predicts each count the table does
// not fix, and all counts are checked in order against the popped results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module range_paint_distinct_color_count_test;

  localparam int SETTLE_CYC = 4000;
  localparam int WDOG_LIMIT = 40000;
  localparam int KEEP_PRED  = -1;

  typedef struct {
    logic               kind;
    int                 lp;
    int                 rp;
    int                 col;
    int                 exp_cnt;
  } row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           push = 1'b0;
  logic                           full;
  logic                           req_type = rpdc_pkg::REQ_PAINT;
  logic [rpdc_pkg::LEN_W-1:0]     left_pos = '0;
  logic [rpdc_pkg::LEN_W-1:0]     right_pos = '0;
  logic [rpdc_pkg::COLOR_W-1:0]   color = '0;
  logic                           empty;
  logic                           pop = 1'b0;
  logic [rpdc_pkg::CNT_W-1:0]     distinct_count;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rpdc_pkg::LEN_W-1:0]     cfg_data = '0;

  int                             row_color [1:rpdc_pkg::MAX_POSITIONS];
  int                             row_len;
  logic [rpdc_pkg::CNT_W-1:0]     count_q [$];
  int                             errors = 0;
  int                             idle_cyc = 0;
  bit                             calm = 1'b0;

  range_paint_distinct_color_count uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_type(req_type),
    .left_pos(left_pos), .right_pos(right_pos), .color(color), .empty(empty),
    .pop(pop), .distinct_count(distinct_count), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic int clamp_pos(input int p);
    if (p < 1) return 1;
    if (p > row_len) return row_len;
    return p;
  endfunction

  task automatic clear_row(input int len);
    row_len = (len < 1) ? 1 : (len > rpdc_pkg::MAX_POSITIONS) ? rpdc_pkg::MAX_POSITIONS : len;
    for (int i = 1; i <= rpdc_pkg::MAX_POSITIONS; i++) row_color[i] = 1;
  endtask

  // apply one accepted request, return predicted count (or -1 for a paint)
  function automatic int predict_req(input logic kind, input int lp, input int rp,
                                     input int col);
    int a, b, t;
    logic [31:0] mask;
    a = clamp_pos(lp);
    b = clamp_pos(rp);
    mask = '0;
    if (a > b) begin
      t = a; a = b; b = t;
    end
    if (kind == rpdc_pkg::REQ_PAINT) begin
      if (col >= 1 && col <= rpdc_pkg::COLOR_COUNT)
        for (int i = a; i <= b; i++) row_color[i] = col;
      return -1;
    end
    for (int i = a; i <= b; i++) mask[row_color[i]-1] = 1'b1;
    return $countones(mask);
  endfunction

  task automatic send_req(input logic kind, input int lp, input int rp, input int col,
                          input int exp_cnt);
    int pc;
    push      <= 1'b1;
    req_type  <= kind;
    left_pos  <= lp[rpdc_pkg::LEN_W-1:0];
    right_pos <= rp[rpdc_pkg::LEN_W-1:0];
    color     <= col[rpdc_pkg::COLOR_W-1:0];
    do @(posedge clk); while (full);
    pc = predict_req(kind, lp, rp, col);
    if (kind == rpdc_pkg::REQ_COUNT)
      count_q.push_back((exp_cnt == KEEP_PRED) ? pc[rpdc_pkg::CNT_W-1:0]
                                               : exp_cnt[rpdc_pkg::CNT_W-1:0]);
  endtask

  task automatic send_gap();
    if (!calm && $urandom_range(0, 99) < 15) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_len(input int v);
    while (count_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v[rpdc_pkg::LEN_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    clear_row(v);
  endtask

  task automatic random_req();
    int lp, rp, col;
    logic kind;
    kind = 1'($urandom_range(0, 1));
    lp = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, row_len);
    case ($urandom_range(0, 9))
      0: rp = $urandom_range(0, 2047);
      1: rp = lp - $urandom_range(0, 31);
      default: rp = lp + $urandom_range(0, 31);
    endcase
    if (rp < 0) rp = 0;
    if (rp > 2047) rp = 2047;
    col = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 30);
    send_req(kind, lp, rp, col, KEEP_PRED);
    send_gap();
  endtask

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= calm || ($urandom_range(0, 99) >= 15);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (count_q.size() == 0)
        report($sformatf("unexpected count %0d", distinct_count));
      else begin
        if (distinct_count !== count_q[0])
          report($sformatf("distinct_count %0d, expected %0d", distinct_count, count_q[0]));
        void'(count_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WDOG_LIMIT) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    row_t tbl [$];
    int lens [$];
    tbl = '{
      '{rpdc_pkg::REQ_COUNT, 1, 1024, 0, 1},
      '{rpdc_pkg::REQ_PAINT, 1, 1024, 30, KEEP_PRED},
      '{rpdc_pkg::REQ_COUNT, 1024, 1, 0, 1},
      '{rpdc_pkg::REQ_PAINT, 5, 3, 0, KEEP_PRED},
      '{rpdc_pkg::REQ_PAINT, 0, 2047, 31, KEEP_PRED},
      '{rpdc_pkg::REQ_COUNT, 0, 2047, 0, 1},
      '{rpdc_pkg::REQ_PAINT, 2047, 0, 2, KEEP_PRED},
      '{rpdc_pkg::REQ_PAINT, 1, 1, 1, KEEP_PRED},
      '{rpdc_pkg::REQ_PAINT, 1024, 1024, 3, KEEP_PRED},
      '{rpdc_pkg::REQ_COUNT, 1, 1024, 0, 3},
      '{rpdc_pkg::REQ_COUNT, 2, 1023, 0, 1},
      '{rpdc_pkg::REQ_PAINT, 10, 20, 17, KEEP_PRED},
      '{rpdc_pkg::REQ_PAINT, 25, 15, 8, KEEP_PRED},
      '{rpdc_pkg::REQ_COUNT, 12, 30, 0, KEEP_PRED},
      '{rpdc_pkg::REQ_PAINT, 512, 513, 31, KEEP_PRED},
      '{rpdc_pkg::REQ_COUNT, 511, 514, 0, KEEP_PRED},
      '{rpdc_pkg::REQ_PAINT, 600, 600, 0, KEEP_PRED},
      '{rpdc_pkg::REQ_COUNT, 600, 600, 0, 1},
      '{rpdc_pkg::REQ_COUNT, 1536, 1025, 0, 1},
      '{rpdc_pkg::REQ_COUNT, 0, 0, 0, 1}
    };
    lens = '{1, 2, 0, 2047, 1024, 0};
    lens[5] = $urandom_range(3, 1023);
    clear_row(rpdc_pkg::MAX_POSITIONS);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (tbl[i]) begin
      send_req(tbl[i].kind, tbl[i].lp, tbl[i].rp, tbl[i].col, tbl[i].exp_cnt);
      send_gap();
    end
    push <= 1'b0;
    calm = 1'b1;
    for (int n = 0; n < 150; n++) random_req();
    calm = 1'b0;
    for (int n = 0; n < 150; n++) random_req();
    foreach (lens[k]) begin
      push <= 1'b0;
      write_len(lens[k]);
      for (int n = 0; n < 170; n++) random_req();
    end
    push <= 1'b0;
    while (count_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
